// ===== rtl/nsvc_pkg.sv =====
`timescale 1ns / 1ps
package nsvc_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] MAX_LENGTH_RESET = 8'd83;
   localparam logic [7:0] MIN_LENGTH       = 8'd6;

   localparam logic [0:0] CSR_STRICT_MODE = 1'd0;
   localparam logic [0:0] CSR_MAX_LENGTH  = 1'd1;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;

   localparam logic [3:0] KIND_INVALID = 4'd0;
   localparam logic [3:0] KIND_UNKNOWN = 4'd1;
   localparam logic [3:0] KIND_RMC     = 4'd2;
   localparam logic [3:0] KIND_GGA     = 4'd3;
   localparam logic [3:0] KIND_GSA     = 4'd4;
   localparam logic [3:0] KIND_GLL     = 4'd5;
   localparam logic [3:0] KIND_GST     = 4'd6;
   localparam logic [3:0] KIND_GSV     = 4'd7;
   localparam logic [3:0] KIND_VTG     = 4'd8;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0] sentence_kind;
      logic [7:0] computed_checksum;
      logic       checksum_present;
   } rsp_type;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       last_byte;
      logic       is_zero;
      logic       printable;
      logic       talker_bad;
      logic       is_dollar;
      logic       is_star;
      logic       is_lf;
      logic       is_cr;
      logic       hex_ok;
      logic [3:0] hex_val;
   } class_type;

   function automatic logic [3:0] kind_of(input logic [23:0] letters);
      logic [3:0] kind;
      case (letters)
         "RMC":   kind = KIND_RMC;
         "GGA":   kind = KIND_GGA;
         "GSA":   kind = KIND_GSA;
         "GLL":   kind = KIND_GLL;
         "GST":   kind = KIND_GST;
         "GSV":   kind = KIND_GSV;
         "VTG":   kind = KIND_VTG;
         default: kind = KIND_UNKNOWN;
      endcase
      return kind;
   endfunction

endpackage

// ===== rtl/nsvc_front.sv =====
`timescale 1ns / 1ps
module nsvc_front
   import nsvc_pkg::*;
(
   input  req_type   req_item,
   output class_type cls_item
);

   logic [7:0] b;

   assign b = req_item.char_byte;

   always_comb begin
      cls_item.char_byte  = b;
      cls_item.last_byte  = req_item.last_byte;
      cls_item.is_zero    = (b == 8'h00);
      cls_item.printable  = (b inside {[8'h20:8'h7E]});
      cls_item.talker_bad = !(b inside {[8'h20:8'h7E]}) || (b == CHAR_COMMA)
                            || (b == CHAR_STAR);
      cls_item.is_dollar  = (b == CHAR_DOLLAR);
      cls_item.is_star    = (b == CHAR_STAR);
      cls_item.is_lf      = (b == CHAR_LF);
      cls_item.is_cr      = (b == CHAR_CR);
      cls_item.hex_ok     = 1'b1;
      cls_item.hex_val    = 4'd0;
      if (b inside {["0":"9"]}) begin
         cls_item.hex_val = 4'(b - 8'h30);
      end else if (b inside {["A":"F"]}) begin
         cls_item.hex_val = 4'(b - 8'h37);
      end else if (b inside {["a":"f"]}) begin
         cls_item.hex_val = 4'(b - 8'h57);
      end else begin
         cls_item.hex_ok = 1'b0;
      end
   end

endmodule

// ===== rtl/nsvc_queue.sv =====
`timescale 1ns / 1ps
module nsvc_queue
   import nsvc_pkg::*;
#(
   parameter int Depth = QUEUE_DEPTH
)
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  class_type in_item,
   output logic      out_valid,
   input  logic      out_ready,
   output class_type out_item
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   class_type           slot_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                push, pop;

   assign in_ready  = (count_ff != CntW'(Depth));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== rtl/nsvc_back.sv =====
`timescale 1ns / 1ps
module nsvc_back
   import nsvc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       strict_mode,
   input  logic [7:0] max_length,
   input  logic       q_valid,
   output logic       q_ready,
   input  class_type  q_item,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   localparam logic [2:0] PH_DOLLAR = 3'd0;
   localparam logic [2:0] PH_BODY   = 3'd1;
   localparam logic [2:0] PH_HEX1   = 3'd2;
   localparam logic [2:0] PH_HEX2   = 3'd3;
   localparam logic [2:0] PH_TRAIL  = 3'd4;
   localparam logic [2:0] PH_SKIP   = 3'd5;

   localparam logic [1:0] TR_NONE = 2'd0;
   localparam logic [1:0] TR_LF   = 2'd1;
   localparam logic [1:0] TR_CR   = 2'd2;
   localparam logic [1:0] TR_CRLF = 2'd3;

   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  xor_ff, xor_in;
   logic [3:0]  nibble_ff, nibble_in;
   logic [7:0]  count_ff, count_in;
   logic [23:0] letters_ff, letters_in;
   logic        talker_ok_ff, talker_ok_in;
   logic [1:0]  trail_ff, trail_in;
   logic        star_ff, star_in;
   logic        reject_ff, reject_in;
   logic        ended_ff, ended_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;
   logic        pop;
   logic [1:0]  trail_cur;

   assign q_ready   = !q_item.last_byte || !rsp_valid_ff || rsp_ready;
   assign pop       = q_valid && q_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      phase_in     = phase_ff;
      xor_in       = xor_ff;
      nibble_in    = nibble_ff;
      count_in     = count_ff;
      letters_in   = letters_ff;
      talker_ok_in = talker_ok_ff;
      trail_in     = trail_ff;
      star_in      = star_ff;
      reject_in    = reject_ff;
      ended_in     = ended_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      trail_cur    = trail_ff;

      if (pop && !ended_ff) begin
         if (q_item.is_zero) begin
            ended_in = 1'b1;
         end else begin
            if (count_ff != 8'hFF) begin
               count_in = count_ff + 1'b1;
            end
            if (count_ff inside {[8'd1:8'd5]}) begin
               if (q_item.talker_bad) begin
                  talker_ok_in = 1'b0;
               end
               if (count_ff >= 8'd3) begin
                  letters_in = {letters_ff[15:0], q_item.char_byte};
               end
            end
            case (phase_ff)
               PH_DOLLAR: begin
                  if (q_item.is_dollar) begin
                     phase_in = PH_BODY;
                  end else begin
                     reject_in = 1'b1;
                     phase_in  = PH_SKIP;
                  end
               end
               PH_BODY: begin
                  if (q_item.is_star) begin
                     star_in  = 1'b1;
                     phase_in = PH_HEX1;
                  end else if (q_item.printable) begin
                     xor_in = xor_ff ^ q_item.char_byte;
                  end else begin
                     phase_in  = PH_TRAIL;
                     trail_cur = TR_NONE;
                  end
               end
               PH_HEX1: begin
                  if (q_item.hex_ok) begin
                     nibble_in = q_item.hex_val;
                     phase_in  = PH_HEX2;
                  end else begin
                     reject_in = 1'b1;
                     phase_in  = PH_SKIP;
                  end
               end
               PH_HEX2: begin
                  if (!q_item.hex_ok || {nibble_ff, q_item.hex_val} != xor_ff) begin
                     reject_in = 1'b1;
                     phase_in  = PH_SKIP;
                  end else begin
                     phase_in = PH_TRAIL;
                  end
               end
               default: begin
               end
            endcase
            if ((phase_ff == PH_TRAIL)
                || (phase_ff == PH_BODY && !q_item.is_star && !q_item.printable)) begin
               if (trail_cur == TR_NONE && q_item.is_lf) begin
                  trail_in = TR_LF;
               end else if (trail_cur == TR_NONE && q_item.is_cr) begin
                  trail_in = TR_CR;
               end else if (trail_cur == TR_CR && q_item.is_lf) begin
                  trail_in = TR_CRLF;
               end else begin
                  reject_in = 1'b1;
                  phase_in  = PH_SKIP;
               end
            end
         end
      end

      if (pop && q_item.last_byte) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.computed_checksum = xor_in;
         rsp_data_in.checksum_present  = star_in;
         if (reject_in || count_in > max_length || count_in < MIN_LENGTH || !talker_ok_in
             || (phase_in != PH_BODY && phase_in != PH_TRAIL)
             || (phase_in == PH_TRAIL && trail_in == TR_CR)
             || (!star_in && strict_mode)) begin
            rsp_data_in.sentence_kind = KIND_INVALID;
         end else begin
            rsp_data_in.sentence_kind = kind_of(letters_in);
         end
         phase_in     = PH_DOLLAR;
         xor_in       = '0;
         nibble_in    = '0;
         count_in     = '0;
         letters_in   = '0;
         talker_ok_in = 1'b1;
         trail_in     = TR_NONE;
         star_in      = 1'b0;
         reject_in    = 1'b0;
         ended_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DOLLAR;
         xor_ff       <= '0;
         nibble_ff    <= '0;
         count_ff     <= '0;
         letters_ff   <= '0;
         talker_ok_ff <= 1'b1;
         trail_ff     <= TR_NONE;
         star_ff      <= 1'b0;
         reject_ff    <= 1'b0;
         ended_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         xor_ff       <= xor_in;
         nibble_ff    <= nibble_in;
         count_ff     <= count_in;
         letters_ff   <= letters_in;
         talker_ok_ff <= talker_ok_in;
         trail_ff     <= trail_in;
         star_ff      <= star_in;
         reject_ff    <= reject_in;
         ended_ff     <= ended_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/nmea_sentence_validate_classify.sv =====
`timescale 1ns / 1ps
// channel  ports                                    direction  moves
// req      req_valid / req_ready / req_data         in         one sentence byte per transfer
// rsp      rsp_valid / rsp_ready / rsp_data         out        one result per last byte
// csr      csr_valid / csr_ready / csr_index, data  in         one register write per transfer
//
// One byte per cycle sustained unless a last byte waits on a full result register; a
// byte is classified into the queue, then the back end updates state and result.
// The queue holds QueueDepth classified bytes; the back end stalls only a last byte
// while the result register is still full, and req_ready drops when the queue fills.
// Synchronous reset clears the sentence state, queue and result valid; strict_mode
// returns to 0 and max_length to 83. csr writes are always taken.
module nmea_sentence_validate_classify
   import nsvc_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [0:0] csr_index,
   input  logic [7:0] csr_data
);

   logic       strict_ff, strict_in;
   logic [7:0] max_len_ff, max_len_in;
   class_type  cls_item;
   class_type  q_item;
   logic       q_valid;
   logic       q_ready;

   assign csr_ready = 1'b1;

   always_comb begin
      strict_in  = strict_ff;
      max_len_in = max_len_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_STRICT_MODE: strict_in  = csr_data[0];
            CSR_MAX_LENGTH:  max_len_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff  <= 1'b0;
         max_len_ff <= MAX_LENGTH_RESET;
      end else begin
         strict_ff  <= strict_in;
         max_len_ff <= max_len_in;
      end
   end

   nsvc_front u_front (
      .req_item (req_data),
      .cls_item (cls_item)
   );

   nsvc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_item   (cls_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   nsvc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .strict_mode (strict_ff),
      .max_length  (max_len_ff),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_item      (q_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
